@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked on every rising clock edge out of reset.
`define ASSERT_CHK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_CHK(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/rva_pkg.sv @@
// ----------------------------------------------------------------------------
// rva_pkg
// Shared types and constants of the run-length view aggregator.
// ----------------------------------------------------------------------------
package rva_pkg;

	localparam int POS_W = 31;
	localparam int VAL_W = 32;
	localparam int SUM_W = 64;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_QUERY  = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [2:0] MODE_MIN     = 3'd0;
	localparam logic [2:0] MODE_MAX     = 3'd1;
	localparam logic [2:0] MODE_SUM     = 3'd2;
	localparam logic [2:0] MODE_POS_MIN = 3'd3;
	localparam logic [2:0] MODE_POS_MAX = 3'd4;

	localparam logic CFG_MODE  = 1'b0;
	localparam logic CFG_NA_RM = 1'b1;

	localparam logic signed [VAL_W-1:0] INT_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] INT_MIN    = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] INT_MIN_P1 = 32'sh8000_0001;

	localparam logic signed [SUM_W-1:0] SUM_HIGH = 64'sd2147483647;
	localparam logic signed [SUM_W-1:0] SUM_LOW  = -64'sd2147483647;

	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [VAL_W-1:0] run_value;
		logic [POS_W-1:0]        run_length;
		logic [POS_W-1:0]        view_start;
		logic [POS_W-1:0]        view_width;
	} rva_in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic                    result_is_na;
		logic                    sum_overflow;
		logic                    past_end;
	} rva_out_t;

	typedef struct packed {
		logic clear;
		logic elem_valid;
		logic is_max;
	} rva_agg_ctl_t;

endpackage

@@ rtl/core/rle_view_aggregator.sv @@
// ----------------------------------------------------------------------------
// rle_view_aggregator
// Run-length store with min / max / weighted-sum / first-extreme-position
// queries over 1-based views.
// ----------------------------------------------------------------------------
// Append and clear beats complete in the cycle that accepts them. A query
// passes through the accepting cycle, a walk back from the cursor to the run
// holding the view start, a scan forward from there to the view end, one run
// per cycle through the single read port of the run store, a drain of the
// two-stage multiply-accumulate unit and the loading of the output register,
// which waits while an earlier result is still held there. The run store is
// not cleared after reset; the run count bounds every read. A finished result
// waits in the output register while the next beat is taken.

`include "assert_macros.svh"

module rle_view_aggregator import rva_pkg::*; #(
	parameter int MAX_RUNS = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  rva_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output rva_out_t   out_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [2:0] cfg_data
);

	localparam int AW = $clog2(MAX_RUNS);
	localparam int CW = $clog2(MAX_RUNS + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_BACK   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [2:0]       agg_mode_q;
	logic             na_rm_q;
	logic [CW-1:0]    count_q;
	logic [POS_W-1:0] total_q;
	logic [AW-1:0]    cursor_q, cursor_d;

	logic [POS_W-1:0] end_mem [MAX_RUNS];
	logic [VAL_W-1:0] val_mem [MAX_RUNS];
	logic [AW-1:0]    rd_addr;
	logic [POS_W-1:0] rd_end_q;
	logic [VAL_W-1:0] rd_val_q;

	// query context
	logic [POS_W-1:0] s_q;
	logic [POS_W-1:0] sm1_q;
	logic [VAL_W-1:0] e_q;
	logic             wnz_q;
	logic [CW-1:0]    idx_q, idx_d;
	logic [POS_W-1:0] prev_end_q, prev_end_d;
	logic             found_q, found_d;
	logic             na_q, na_d;

	// element stage feeding the shared unit
	logic                    v_s1_q;
	logic                    issue;
	logic signed [VAL_W-1:0] val_s1;
	logic [POS_W-1:0]        cnt_s1;
	logic [VAL_W-1:0]        pos_s1;

	logic             out_valid_q;
	rva_out_t         out_data_q;
	rva_out_t         res_w;

	logic             in_acc;
	logic             is_query;
	logic [VAL_W-1:0] app_sum;
	logic             app_we;
	logic [2:0]       mode_eff;
	logic             is_max;
	logic             is_sum;
	logic             is_pos;

	logic [CW-1:0]    idx0;
	logic [CW-1:0]    idx_m1;
	logic [CW-1:0]    idx_m2;
	logic [CW-1:0]    idx_p1;
	logic [CW-1:0]    cnt_m1;
	logic             more;
	logic             cur_na;
	logic [POS_W-1:0] b_w;
	logic [POS_W-1:0] base_w;
	logic             lo_above_s;

	rva_agg_ctl_t            agg_ctl;
	logic                    agg_busy;
	logic signed [VAL_W-1:0] agg_best;
	logic [VAL_W-1:0]        agg_pos;
	logic signed [SUM_W-1:0] agg_sum;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign is_query = in_acc && (in_data.req_type == REQ_QUERY);

	assign app_sum = VAL_W'(total_q) + VAL_W'(in_data.run_length);
	assign app_we  = in_acc && (in_data.req_type == REQ_APPEND) &&
		(count_q != CW'(MAX_RUNS)) && (in_data.run_length != '0) && !app_sum[VAL_W-1];

	assign mode_eff = (agg_mode_q > MODE_POS_MAX) ? MODE_MIN : agg_mode_q;
	assign is_max   = (mode_eff == MODE_MAX) || (mode_eff == MODE_POS_MAX);
	assign is_sum   = (mode_eff == MODE_SUM);
	assign is_pos   = (mode_eff == MODE_POS_MIN) || (mode_eff == MODE_POS_MAX);

	assign idx0   = (CW'(cursor_q) >= count_q) ? '0 : CW'(cursor_q);
	assign idx_m1 = idx_q - CW'(1);
	assign idx_m2 = idx_q - CW'(2);
	assign idx_p1 = idx_q + CW'(1);
	assign cnt_m1 = count_q - CW'(1);
	assign more   = idx_p1 < count_q;
	assign cur_na = (rd_val_q == VAL_W'(INT_MIN));

	// overlap of the current run with the view
	assign lo_above_s = prev_end_q >= s_q;
	assign b_w        = (VAL_W'(rd_end_q) < e_q) ? rd_end_q : e_q[POS_W-1:0];
	assign base_w     = lo_above_s ? prev_end_q : sm1_q;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		prev_end_d = prev_end_q;
		found_d    = found_q;
		na_d       = na_q;
		cursor_d   = cursor_q;
		rd_addr    = idx_p1[AW-1:0];
		issue      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = '0;
				if (is_query) begin
					idx_d      = idx0;
					prev_end_d = '0;
					found_d    = 1'b0;
					na_d       = 1'b0;
					cursor_d   = idx0[AW-1:0];
					if (count_q == '0) begin
						state_d = ST_DRAIN;
					end else if (idx0 != '0) begin
						rd_addr = idx_m1[AW-1:0];
						idx_d   = idx0;
						state_d = ST_BACK;
					end else begin
						state_d = ST_SCAN;
					end
				end
				if (is_query && idx0 != '0) begin
					rd_addr = AW'(idx0 - CW'(1));
				end
				if (in_acc && in_data.req_type == REQ_CLEAR) begin
					cursor_d = '0;
				end
			end
			ST_BACK: begin
				// rd_end_q holds the end of the run before idx_q
				if (rd_end_q >= s_q) begin
					idx_d = idx_m1;
					if (idx_q == CW'(1)) begin
						rd_addr    = '0;
						prev_end_d = '0;
						state_d    = ST_SCAN;
					end else begin
						rd_addr = idx_m2[AW-1:0];
					end
				end else begin
					rd_addr    = idx_q[AW-1:0];
					prev_end_d = rd_end_q;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_addr = idx_p1[AW-1:0];
				if (!found_q && rd_end_q < s_q) begin
					prev_end_d = rd_end_q;
					idx_d      = idx_p1;
					if (!more) begin
						cursor_d = cnt_m1[AW-1:0];
						state_d  = ST_DRAIN;
					end
				end else begin
					if (!found_q) begin
						found_d  = 1'b1;
						cursor_d = idx_q[AW-1:0];
					end
					if (!wnz_q || VAL_W'(prev_end_q) >= e_q) begin
						state_d = ST_DRAIN;
					end else if (cur_na && !na_rm_q) begin
						na_d    = 1'b1;
						state_d = ST_DRAIN;
					end else begin
						issue      = !cur_na;
						prev_end_d = rd_end_q;
						idx_d      = idx_p1;
						if (!more) begin
							state_d = ST_DRAIN;
						end
					end
				end
			end
			ST_DRAIN: begin
				if (!v_s1_q && !agg_busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			agg_mode_q  <= MODE_MIN;
			na_rm_q     <= 1'b0;
			count_q     <= '0;
			total_q     <= '0;
			cursor_q    <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			na_q        <= 1'b0;
			v_s1_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			found_q  <= found_d;
			na_q     <= na_d;
			cursor_q <= cursor_d;
			v_s1_q   <= issue;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:  agg_mode_q <= cfg_data;
					CFG_NA_RM: na_rm_q    <= cfg_data[0];
					default:   ;
				endcase
			end
			if (app_we) begin
				count_q <= count_q + CW'(1);
				total_q <= app_sum[POS_W-1:0];
			end
			if (in_acc && in_data.req_type == REQ_CLEAR) begin
				count_q <= '0;
				total_q <= '0;
			end
			if (state_q == ST_RESULT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prev_end_q <= prev_end_d;
		if (is_query) begin
			s_q   <= (in_data.view_start == '0) ? POS_W'(1) : in_data.view_start;
			sm1_q <= (in_data.view_start == '0) ? '0 : in_data.view_start - POS_W'(1);
			e_q   <= VAL_W'(in_data.view_start) + VAL_W'(in_data.view_width) - VAL_W'(1);
			wnz_q <= (in_data.view_width != '0);
		end
		if (issue) begin
			val_s1 <= $signed(rd_val_q);
			cnt_s1 <= b_w - base_w;
			pos_s1 <= lo_above_s ? VAL_W'(prev_end_q) + VAL_W'(1) : VAL_W'(s_q);
		end
		if (state_q == ST_RESULT && (!out_valid_q || out_ready)) begin
			out_data_q <= res_w;
		end
	end

	// run store
	always_ff @(posedge clk) begin
		if (app_we) begin
			end_mem[count_q[AW-1:0]] <= app_sum[POS_W-1:0];
			val_mem[count_q[AW-1:0]] <= in_data.run_value;
		end
		rd_end_q <= end_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	assign agg_ctl.clear      = is_query;
	assign agg_ctl.elem_valid = v_s1_q;
	assign agg_ctl.is_max     = is_max;

	rva_agg_unit u_agg (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (agg_ctl),
		.init_pos   (VAL_W'(in_data.view_start)),
		.elem_value (val_s1),
		.elem_count (cnt_s1),
		.elem_pos   (pos_s1),
		.busy       (agg_busy),
		.best       (agg_best),
		.best_pos   (agg_pos),
		.sum        (agg_sum)
	);

	always_comb begin
		res_w.result_is_na = na_q;
		res_w.sum_overflow = 1'b0;
		res_w.past_end     = wnz_q && (e_q > VAL_W'(total_q));
		if (na_q) begin
			res_w.result_value = INT_MIN;
		end else if (is_sum) begin
			if (agg_sum > SUM_HIGH) begin
				res_w.result_value = INT_MAX;
				res_w.sum_overflow = 1'b1;
			end else if (agg_sum < SUM_LOW) begin
				res_w.result_value = INT_MIN_P1;
				res_w.sum_overflow = 1'b1;
			end else begin
				res_w.result_value = agg_sum[VAL_W-1:0];
			end
		end else if (is_pos) begin
			res_w.result_value = $signed(agg_pos);
		end else begin
			res_w.result_value = agg_best;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`ASSERT_IMPLY(a_scan_in_range, clk, arst_n, state_q == ST_SCAN, idx_q < count_q)
	`ASSERT_IMPLY(a_idle_quiet, clk, arst_n, in_ready, !v_s1_q && !agg_busy)
	`ASSERT_CHK(a_count_bound, clk, arst_n, count_q <= CW'(MAX_RUNS))
	`ASSERT_IMPLY(a_out_from_result, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_RESULT))

endmodule

@@ rtl/core/rva_agg_unit.sv @@
// ----------------------------------------------------------------------------
// rva_agg_unit
// Shared compare and multiply-accumulate unit: folds one covered run per beat
// into the running minimum/maximum with its position and the weighted sum.
// ----------------------------------------------------------------------------
module rva_agg_unit import rva_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rva_agg_ctl_t            ctl,
	input  logic [VAL_W-1:0]        init_pos,
	input  logic signed [VAL_W-1:0] elem_value,
	input  logic [POS_W-1:0]        elem_count,
	input  logic [VAL_W-1:0]        elem_pos,
	output logic                    busy,
	output logic signed [VAL_W-1:0] best,
	output logic [VAL_W-1:0]        best_pos,
	output logic signed [SUM_W-1:0] sum
);

	logic                    v_s2;
	logic signed [SUM_W-1:0] prod_s2;
	logic signed [SUM_W-1:0] prod_w;
	logic signed [VAL_W-1:0] best_q;
	logic [VAL_W-1:0]        pos_q;
	logic                    any_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    better;

	assign prod_w = elem_value * $signed({1'b0, elem_count});
	assign better = !any_q || (ctl.is_max ? (elem_value > best_q) : (elem_value < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			any_q <= 1'b0;
		end else if (ctl.clear) begin
			v_s2  <= 1'b0;
			any_q <= 1'b0;
		end else begin
			v_s2 <= ctl.elem_valid;
			if (ctl.elem_valid) begin
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			best_q <= ctl.is_max ? INT_MIN : INT_MAX;
			pos_q  <= init_pos;
			sum_q  <= '0;
		end else begin
			if (ctl.elem_valid) begin
				prod_s2 <= prod_w;
				// strict compare keeps the first extreme
				if (better) begin
					best_q <= elem_value;
					pos_q  <= elem_pos;
				end
			end
			if (v_s2) begin
				sum_q <= sum_q + prod_s2;
			end
		end
	end

	assign busy     = v_s2;
	assign best     = best_q;
	assign best_pos = pos_q;
	assign sum      = sum_q;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rle_view_aggregator: run appends, clears and view
// queries go in on a bursty valid/ready stream while results are taken under a
// shifting stall pattern. A local run store predicts each query's aggregate.
// ----------------------------------------------------------------------------
module tb_top;
	import rva_pkg::*;

	localparam int MAX_RUNS = 1024;
	localparam int RW = $clog2(MAX_RUNS);
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [2:0] MODE_SPARE_TOP = 3'd7;
	localparam logic [32:0] POS_CAP = 33'h0_7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rva_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rva_out_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [2:0] cfg_data = 3'd0;

	rle_view_aggregator #(.MAX_RUNS(MAX_RUNS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local copy of the run store and registers
	logic signed [31:0] run_val [MAX_RUNS];
	logic [31:0] run_end [MAX_RUNS];
	int run_count = 0;
	logic [31:0] loaded_total = '0;
	logic [2:0] agg_mode = MODE_MIN;
	logic na_rm = 1'b0;

	rva_in_t beats_to_send[$];
	rva_out_t pending_aggs[$];
	rva_out_t want_agg;
	int err_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	logic [31:0] stall_cyc = '0;

	// generator-side view of the store, used to aim queries
	logic [31:0] gen_total = '0;
	int gen_count = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic report(input string what, input longint got, input longint want);
		err_count++;
		if (err_count <= 40)
			$display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
	endtask

	function automatic rva_out_t predict_view(input logic [30:0] vs, input logic [30:0] vw);
		logic [2:0] m;
		longint unsigned s, e, lo, hi, a, b, pos;
		longint best, sum, v;
		bit is_empty, past, is_max, any, na, ovf, done;
		rva_out_t r;
		m = (agg_mode > MODE_POS_MAX) ? MODE_MIN : agg_mode;
		s = (vs == 0) ? 64'd1 : 64'(vs);
		e = 64'(vs) + 64'(vw) - 64'd1;
		is_empty = (vs == 0 && vw == 0) || (e < s);
		past = (vw != 0) && (e > 64'(loaded_total));
		is_max = (m == MODE_MAX || m == MODE_POS_MAX);
		best = is_max ? 64'(INT_MIN) : 64'(INT_MAX);
		sum = 0;
		pos = 64'(vs);
		any = 0;
		na = 0;
		ovf = 0;
		done = is_empty;
		for (int k = 0; k < run_count && !done; k++) begin
			lo = (k == 0) ? 64'd1 : 64'(run_end[RW'(k - 1)]) + 64'd1;
			hi = 64'(run_end[RW'(k)]);
			if (lo > e) begin
				done = 1;
			end else if (hi >= s) begin
				a = (lo > s) ? lo : s;
				b = (hi < e) ? hi : e;
				if (run_val[RW'(k)] == INT_MIN) begin
					if (!na_rm) begin
						na = 1;
						done = 1;
					end
				end else begin
					v = longint'(run_val[RW'(k)]);
					if (m == MODE_SUM) begin
						sum += v * longint'(b - a + 64'd1);
					end else if (is_max) begin
						if (!any || v > best) begin
							best = v;
							pos = a;
						end
					end else if (!any || v < best) begin
						best = v;
						pos = a;
					end
					any = 1;
				end
			end
		end
		if (na) begin
			r.result_value = INT_MIN;
		end else if (m == MODE_SUM) begin
			if (sum > SUM_HIGH) begin
				sum = SUM_HIGH;
				ovf = 1;
			end else if (sum < SUM_LOW) begin
				sum = SUM_LOW;
				ovf = 1;
			end
			r.result_value = sum[31:0];
		end else if (m == MODE_POS_MIN || m == MODE_POS_MAX) begin
			r.result_value = pos[31:0];
		end else begin
			r.result_value = best[31:0];
		end
		r.result_is_na = na;
		r.sum_overflow = ovf;
		r.past_end = past;
		return r;
	endfunction

	// update the local store with one accepted beat
	task automatic absorb_request(input rva_in_t it);
		case (it.req_type)
			REQ_APPEND: begin
				if (run_count < MAX_RUNS && it.run_length != 0 &&
				    33'(loaded_total) + 33'(it.run_length) <= POS_CAP) begin
					loaded_total = loaded_total + 32'(it.run_length);
					run_val[RW'(run_count)] = it.run_value;
					run_end[RW'(run_count)] = loaded_total;
					run_count++;
				end
			end
			REQ_CLEAR: begin
				run_count = 0;
				loaded_total = '0;
			end
			REQ_QUERY: begin
				pending_aggs.push_back(predict_view(it.view_start, it.view_width));
			end
			default: begin
			end
		endcase
	endtask

	// sender: bursts of beats with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				absorb_request(in_data);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (beats_to_send.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= beats_to_send.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall style changes with stall_cyc[10:9], through four patterns
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_aggs.size() == 0) begin
					report("result with none pending", longint'(out_data.result_value),
						64'sd0);
				end else begin
					want_agg = pending_aggs.pop_front();
					if (out_data.result_value !== want_agg.result_value)
						report("result_value", longint'(out_data.result_value),
							longint'(want_agg.result_value));
					if (out_data.result_is_na !== want_agg.result_is_na)
						report("result_is_na", longint'(out_data.result_is_na),
							longint'(want_agg.result_is_na));
					if (out_data.sum_overflow !== want_agg.sum_overflow)
						report("sum_overflow", longint'(out_data.sum_overflow),
							longint'(want_agg.sum_overflow));
					if (out_data.past_end !== want_agg.past_end)
						report("past_end", longint'(out_data.past_end),
							longint'(want_agg.past_end));
				end
			end
			case (stall_cyc[10:9])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= ($urandom_range(0, 3) != 0);
				2'd2: out_ready <= (stall_cyc[2:0] < 3'd3);
				default: out_ready <= ($urandom_range(0, 1) != 0);
			endcase
			stall_cyc <= stall_cyc + 32'd1;
		end
	end

	function automatic rva_in_t rand_beat(input logic [1:0] req);
		rva_in_t t;
		t.req_type = req;
		t.run_value = $urandom;
		t.run_length = 31'($urandom);
		t.view_start = 31'($urandom);
		t.view_width = 31'($urandom);
		return t;
	endfunction

	function automatic logic signed [31:0] rand_value();
		logic signed [31:0] v;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 2) begin
			v = INT_MIN;
		end else if (sel == 2) begin
			v = INT_MAX;
		end else if (sel == 3) begin
			v = INT_MIN_P1;
		end else if (sel < 12) begin
			v = $urandom_range(0, 40);
			v = v - 32'sd20;
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	function automatic logic [30:0] rand_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 85)
			return 31'($urandom_range(1, 8));
		else if (sel < 95)
			return 31'($urandom_range(1, 1000));
		else if (sel < 99)
			return 31'($urandom);
		return '0;
	endfunction

	task automatic push_plain(input logic [1:0] req);
		if (req == REQ_CLEAR) begin
			gen_total = '0;
			gen_count = 0;
		end
		beats_to_send.push_back(rand_beat(req));
	endtask

	task automatic push_append(input logic signed [31:0] v, input logic [30:0] len);
		rva_in_t t;
		t = rand_beat(REQ_APPEND);
		t.run_value = v;
		t.run_length = len;
		if (gen_count < MAX_RUNS && len != 0 && 33'(gen_total) + 33'(len) <= POS_CAP) begin
			gen_total = gen_total + 32'(len);
			gen_count++;
		end
		beats_to_send.push_back(t);
	endtask

	task automatic push_query(input logic [30:0] vs, input logic [30:0] vw);
		rva_in_t t;
		t = rand_beat(REQ_QUERY);
		t.view_start = vs;
		t.view_width = vw;
		beats_to_send.push_back(t);
	endtask

	// mostly views inside the loaded range, some off the end or degenerate
	task automatic push_query_random();
		logic [30:0] vs, vw;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 3)
			vs = '0;
		else if (gen_total == 0 || sel < 8)
			vs = 31'($urandom);
		else
			vs = 31'($urandom_range(1, gen_total));
		sel = $urandom_range(0, 99);
		if (sel < 5)
			vw = '0;
		else if (sel < 70 && 32'(vs) <= gen_total)
			vw = 31'($urandom_range(1, gen_total - 32'(vs) + 32'd1));
		else if (sel < 85)
			vw = 31'($urandom_range(1, 64));
		else
			vw = 31'($urandom);
		push_query(vs, vw);
	endtask

	// nothing in flight: all beats taken, all results back, then a short pause
	task automatic wait_quiet();
		@(negedge clk);
		while (beats_to_send.size() != 0 || in_valid || pending_aggs.size() != 0)
			@(negedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [2:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MODE)
			agg_mode = d;
		else
			na_rm = d[0];
	endtask

	task automatic set_config(input logic [2:0] m, input logic [2:0] na_word);
		wait_quiet();
		write_reg(CFG_MODE, m);
		write_reg(CFG_NA_RM, na_word);
	endtask

	initial begin
		int sel, n;
		logic [2:0] m;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty store, NA handling, refused appends, odd views
		set_config(MODE_MIN, 3'd0);
		push_query(31'd1, 31'd5);
		push_query(31'd0, 31'd0);
		push_append(32'sd5, 31'd3);
		push_append(INT_MIN, 31'd2);
		push_append(-32'sd7, 31'd1);
		push_append(32'sd9, 31'd0);
		push_plain(REQ_UNUSED);
		push_query(31'd1, 31'd3);
		push_query(31'd0, 31'd6);
		push_query(31'd4, 31'd0);

		set_config(MODE_SUM, 3'd1);
		push_query(31'd1, 31'd6);
		push_query(31'd2, 31'h7FFF_FFFF);

		set_config(MODE_POS_MIN, 3'd0);
		push_query(31'd0, 31'd4);

		// total length at its ceiling, high sum saturation
		set_config(MODE_SUM, 3'd0);
		push_plain(REQ_CLEAR);
		push_append(INT_MAX, 31'h7FFF_FFFE);
		push_append(INT_MIN_P1, 31'd1);
		push_append(32'sd1, 31'd1);
		push_query(31'd1, 31'h7FFF_FFFE);
		push_query(31'h7FFF_FFFF, 31'd1);

		set_config(MODE_POS_MAX, 3'd1);
		push_query(31'h7FFF_FFFF, 31'h7FFF_FFFF);
		push_query(31'd1, 31'h7FFF_FFFF);

		set_config(MODE_SPARE_TOP, 3'd1);
		push_query(31'd1, 31'h7FFF_FFFF);

		set_config(MODE_SUM, 3'd1);
		push_plain(REQ_CLEAR);
		push_append(INT_MIN_P1, 31'd2);
		push_query(31'd1, 31'd2);

		// store filled to the brim, a couple of appends refused
		set_config(MODE_SUM, 3'd0);
		push_plain(REQ_CLEAR);
		for (int k = 0; k < MAX_RUNS + 2; k++)
			push_append(rand_value(), 31'($urandom_range(1, 3)));
		push_query(31'd1, 31'(gen_total));
		push_query_random();
		set_config(MODE_POS_MAX, 3'd1);
		push_query(31'd1, 31'h7FFF_FFFF);
		push_query_random();
		set_config(MODE_MIN, 3'd1);
		push_query(31'(gen_total), 31'd1);
		push_query(31'd1, 31'd2);

		// random rounds; each starts from an idle block with fresh settings
		for (int rnd = 0; rnd < 40; rnd++) begin
			sel = $urandom_range(0, 9);
			if (sel <= 4)
				m = 3'(sel);
			else if (sel <= 7)
				m = 3'($urandom_range(0, 4));
			else
				m = 3'($urandom_range(5, 7));
			set_config(m, 3'($urandom_range(0, 7)));
			if (gen_count == 0 || $urandom_range(0, 3) == 0) begin
				push_plain(REQ_CLEAR);
				n = $urandom_range(1, 30);
			end else begin
				n = $urandom_range(0, 4);
			end
			for (int k = 0; k < n; k++)
				push_append(rand_value(), rand_len());
			n = $urandom_range(8, 16);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 99) < 15) begin
					case ($urandom_range(0, 3))
						0: push_plain(REQ_UNUSED);
						1: push_append(rand_value(), '0);
						2: push_append(rand_value(), rand_len());
						default: begin
							if ($urandom_range(0, 4) == 0)
								push_plain(REQ_CLEAR);
						end
					endcase
				end
				push_query_random();
			end
		end

		wait_quiet();
		repeat (48) @(posedge clk);
		if (err_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
